>>> rtl/core/kaf_pkg.sv
package kaf_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned REG_W  = 31;
    localparam logic [15:0] DT_DEFAULT = 16'd655;

    localparam logic [REG_W-1:0] ANGLE_NOISE_RST   = 31'd268435;
    localparam logic [REG_W-1:0] BIAS_NOISE_RST    = 31'd805306;
    localparam logic [REG_W-1:0] MEASURE_NOISE_RST = 31'd8053064;

    typedef enum logic [1:0] {
        CFG_ANGLE_NOISE   = 2'd0,
        CFG_BIAS_NOISE    = 2'd1,
        CFG_MEASURE_NOISE = 2'd2
    } cfg_idx_t;

    // datapath micro-operations, one per controller step
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ANG_PRED,
        OP_T,
        OP_INNER,
        OP_P00,
        OP_P01P10,
        OP_P11,
        OP_S,
        OP_DIV_K0,
        OP_DIV_K1,
        OP_Y,
        OP_ANG_COR,
        OP_BIAS_COR,
        OP_NP00,
        OP_NP01,
        OP_NP10,
        OP_NP11,
        OP_STORE
    } op_t;

    typedef struct packed {
        op_t  op;
        logic div_start;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic s_pos;
    } status_t;

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [31:0] r;
        if (v > 72'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -72'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // round to nearest, ties upward, arithmetic shift
    function automatic logic signed [71:0] rshift16(input logic signed [71:0] v);
        logic signed [71:0] a;
        a = v + 72'sd32768;
        return a >>> 16;
    endfunction

    function automatic logic signed [71:0] rshift28(input logic signed [71:0] v);
        logic signed [71:0] a;
        a = v + 72'sd134217728;
        return a >>> 28;
    endfunction

endpackage

>>> rtl/core/kaf_divider.sv
// restoring divider: signed 60-bit dividend over positive 33-bit divisor,
// truncating toward zero, one quotient bit per cycle
module kaf_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [59:0]  dividend,
    input  logic        [32:0]  divisor,
    output logic                busy,
    output logic signed [31:0]  quotient
);

    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        neg_reg, neg_next;
    logic [59:0] q_reg, q_next;
    logic [33:0] rem_reg, rem_next;
    logic [32:0] den_reg, den_next;
    logic [33:0] trial;
    logic [60:0] qs;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg[32:0], q_reg[59]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd60;
            neg_next  = dividend[59];
            q_next    = dividend[59] ? 60'(-dividend) : 60'(dividend);
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                q_next   = {q_reg[58:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[58:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign qs       = neg_reg ? -{1'b0, q_reg} : {1'b0, q_reg};
    assign busy     = busy_reg;
    assign quotient = kaf_pkg::sat32(72'(signed'(qs)));

endmodule

>>> rtl/core/kaf_datapath.sv
// per-axis state, noise registers, one shared multiplier and the divider
module kaf_datapath #(
    parameter int unsigned NUM_AXES = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kaf_pkg::cmd_t        cmd,
    output kaf_pkg::status_t     status,
    input  logic                 in_take,
    input  logic                 axis,
    input  logic signed [31:0]   measured_angle,
    input  logic signed [25:0]   gyro_rate,
    input  logic [15:0]          time_step,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [30:0]          cfg_data,
    output logic signed [31:0]   result
);

    localparam int unsigned AX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    logic [30:0] angle_noise_reg, bias_noise_reg, measure_noise_reg;

    logic signed [31:0] ang_st_reg [NUM_AXES];
    logic signed [31:0] bias_st_reg [NUM_AXES];
    logic signed [31:0] p_st_reg [NUM_AXES][4];

    logic               axis_reg;
    logic               valid_ax_reg;
    logic signed [31:0] meas_reg;
    logic signed [25:0] rate_reg;
    logic [15:0]        dt_reg;

    logic signed [31:0] ang_reg, bias_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] t_reg, k0_reg, k1_reg, y_reg, res_reg;
    logic signed [35:0] inner_reg;
    logic signed [33:0] s_reg;
    logic signed [31:0] np00_reg, np01_reg, np10_reg;

    logic [AX_W-1:0]    ax_idx;
    logic               div_busy;
    logic signed [31:0] div_q;
    logic signed [59:0] div_num;

    // shared multiplier operands
    logic signed [36:0] ma;
    logic signed [32:0] mb;
    logic signed [71:0] prod;

    assign ax_idx = AX_W'(axis_reg);

    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (cmd.op)
            kaf_pkg::OP_ANG_PRED:
            begin
                ma = 37'(signed'({1'b0, dt_reg}));
                mb = 33'(rate_reg) - 33'(bias_reg);
            end
            kaf_pkg::OP_T:
            begin
                ma = 37'(signed'({1'b0, dt_reg}));
                mb = 33'(p11_reg);
            end
            kaf_pkg::OP_P00:
            begin
                ma = 37'(inner_reg);
                mb = 33'(signed'({1'b0, dt_reg}));
            end
            kaf_pkg::OP_P11:
            begin
                ma = 37'(signed'({1'b0, bias_noise_reg}));
                mb = 33'(signed'({1'b0, dt_reg}));
            end
            kaf_pkg::OP_ANG_COR:
            begin
                ma = 37'(k0_reg);
                mb = 33'(y_reg);
            end
            kaf_pkg::OP_BIAS_COR:
            begin
                ma = 37'(k1_reg);
                mb = 33'(y_reg);
            end
            kaf_pkg::OP_NP00:
            begin
                ma = 37'(k0_reg);
                mb = 33'(p00_reg);
            end
            kaf_pkg::OP_NP01:
            begin
                ma = 37'(k0_reg);
                mb = 33'(p01_reg);
            end
            kaf_pkg::OP_NP10:
            begin
                ma = 37'(k1_reg);
                mb = 33'(p00_reg);
            end
            kaf_pkg::OP_NP11:
            begin
                ma = 37'(k1_reg);
                mb = 33'(p01_reg);
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign prod = 72'(ma) * 72'(mb);

    assign div_num = (cmd.op == kaf_pkg::OP_DIV_K1) ? {p10_reg, 28'd0} : {p00_reg, 28'd0};

    kaf_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_num),
        .divisor  (s_reg[32:0]),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign status.div_busy = div_busy;
    assign status.s_pos    = (s_reg > 34'sd0);
    assign result          = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_noise_reg   <= kaf_pkg::ANGLE_NOISE_RST;
            bias_noise_reg    <= kaf_pkg::BIAS_NOISE_RST;
            measure_noise_reg <= kaf_pkg::MEASURE_NOISE_RST;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                ang_st_reg[i]  <= '0;
                bias_st_reg[i] <= '0;
                for (int j = 0; j < 4; j++)
                    p_st_reg[i][j] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    kaf_pkg::CFG_ANGLE_NOISE:   angle_noise_reg   <= cfg_data;
                    kaf_pkg::CFG_BIAS_NOISE:    bias_noise_reg    <= cfg_data;
                    kaf_pkg::CFG_MEASURE_NOISE: measure_noise_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.op == kaf_pkg::OP_STORE && valid_ax_reg)
            begin
                ang_st_reg[ax_idx]  <= ang_reg;
                bias_st_reg[ax_idx] <= bias_reg;
                p_st_reg[ax_idx][0] <= np00_reg;
                p_st_reg[ax_idx][1] <= np01_reg;
                p_st_reg[ax_idx][2] <= np10_reg;
                p_st_reg[ax_idx][3] <= p11_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            axis_reg     <= axis;
            valid_ax_reg <= (32'(axis) < NUM_AXES);
            meas_reg     <= measured_angle;
            rate_reg     <= gyro_rate;
            dt_reg       <= (time_step == 16'd0) ? kaf_pkg::DT_DEFAULT : time_step;
        end
        unique case (cmd.op)
            kaf_pkg::OP_LOAD:
            begin
                ang_reg  <= ang_st_reg[ax_idx];
                bias_reg <= bias_st_reg[ax_idx];
                p00_reg  <= p_st_reg[ax_idx][0];
                p01_reg  <= p_st_reg[ax_idx][1];
                p10_reg  <= p_st_reg[ax_idx][2];
                p11_reg  <= p_st_reg[ax_idx][3];
            end
            kaf_pkg::OP_ANG_PRED:
                ang_reg <= kaf_pkg::sat32(72'(ang_reg) + kaf_pkg::rshift16(prod));
            kaf_pkg::OP_T:
                t_reg <= 32'(kaf_pkg::rshift16(prod));
            kaf_pkg::OP_INNER:
                inner_reg <= 36'(t_reg) - 36'(p01_reg) - 36'(p10_reg)
                             + 36'(signed'({1'b0, angle_noise_reg}));
            kaf_pkg::OP_P00:
                p00_reg <= kaf_pkg::sat32(72'(p00_reg) + kaf_pkg::rshift16(prod));
            kaf_pkg::OP_P01P10:
            begin
                p01_reg <= kaf_pkg::sat32(72'(p01_reg) - 72'(t_reg));
                p10_reg <= kaf_pkg::sat32(72'(p10_reg) - 72'(t_reg));
            end
            kaf_pkg::OP_P11:
                p11_reg <= kaf_pkg::sat32(72'(p11_reg) + kaf_pkg::rshift16(prod));
            kaf_pkg::OP_S:
            begin
                s_reg  <= 34'(p00_reg) + 34'(signed'({1'b0, measure_noise_reg}));
                k0_reg <= '0;
                k1_reg <= '0;
            end
            kaf_pkg::OP_DIV_K0:
                if (!div_busy) k0_reg <= div_q;
            kaf_pkg::OP_DIV_K1:
                if (!div_busy) k1_reg <= div_q;
            kaf_pkg::OP_Y:
                y_reg <= kaf_pkg::sat32(72'(meas_reg) - 72'(ang_reg));
            kaf_pkg::OP_ANG_COR:
                ang_reg <= kaf_pkg::sat32(72'(ang_reg) + kaf_pkg::rshift28(prod));
            kaf_pkg::OP_BIAS_COR:
                bias_reg <= kaf_pkg::sat32(72'(bias_reg) + kaf_pkg::rshift28(prod));
            kaf_pkg::OP_NP00:
                np00_reg <= kaf_pkg::sat32(72'(p00_reg) - kaf_pkg::rshift28(prod));
            kaf_pkg::OP_NP01:
                np01_reg <= kaf_pkg::sat32(72'(p01_reg) - kaf_pkg::rshift28(prod));
            kaf_pkg::OP_NP10:
                np10_reg <= kaf_pkg::sat32(72'(p10_reg) - kaf_pkg::rshift28(prod));
            kaf_pkg::OP_NP11:
                p11_reg <= kaf_pkg::sat32(72'(p11_reg) - kaf_pkg::rshift28(prod));
            kaf_pkg::OP_STORE:
                res_reg <= valid_ax_reg ? ang_reg : 32'sd0;
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_store_needs_valid_axis: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == kaf_pkg::OP_STORE && !valid_ax_reg) |=> (res_reg == 32'sd0))
        else $error("out-of-range axis produced nonzero result");
    a_no_start_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("divider restarted while busy");
    a_div_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> div_busy)
        else $error("divider did not start");
`endif

endmodule

>>> rtl/core/kaf_ctrl.sv
// sequencer stepping the datapath through one filter update
module kaf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              in_take,
    output logic              out_valid,
    input  logic              out_stall,
    output kaf_pkg::cmd_t     cmd,
    input  kaf_pkg::status_t  status
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_LOAD, ST_ANG, ST_T, ST_INNER, ST_P00, ST_P0110, ST_P11, ST_S,
        ST_K0_GO, ST_K0_WAIT, ST_K1_GO, ST_K1_WAIT, ST_Y, ST_ACOR, ST_BCOR,
        ST_N00, ST_N01, ST_N10, ST_N11, ST_STORE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // a new item may start in the idle state once the previous result slot is free or leaving
    assign in_stall  = !(state_reg == ST_IDLE && (!out_valid_reg || !out_stall));
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.op         = kaf_pkg::OP_NONE;
        cmd.div_start  = 1'b0;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:    if (in_take) state_next = ST_LOAD;
            ST_LOAD:    begin cmd.op = kaf_pkg::OP_LOAD;     state_next = ST_ANG;   end
            ST_ANG:     begin cmd.op = kaf_pkg::OP_ANG_PRED; state_next = ST_T;     end
            ST_T:       begin cmd.op = kaf_pkg::OP_T;        state_next = ST_INNER; end
            ST_INNER:   begin cmd.op = kaf_pkg::OP_INNER;    state_next = ST_P00;   end
            ST_P00:     begin cmd.op = kaf_pkg::OP_P00;      state_next = ST_P0110; end
            ST_P0110:   begin cmd.op = kaf_pkg::OP_P01P10;   state_next = ST_P11;   end
            ST_P11:     begin cmd.op = kaf_pkg::OP_P11;      state_next = ST_S;     end
            ST_S:       begin cmd.op = kaf_pkg::OP_S;        state_next = ST_K0_GO; end
            ST_K0_GO:
            begin
                if (status.s_pos)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_K0_WAIT;
                end
                else
                    state_next = ST_Y;
            end
            ST_K0_WAIT:
            begin
                cmd.op = kaf_pkg::OP_DIV_K0;
                if (!status.div_busy) state_next = ST_K1_GO;
            end
            ST_K1_GO:
            begin
                cmd.op        = kaf_pkg::OP_DIV_K1;
                cmd.div_start = 1'b1;
                state_next    = ST_K1_WAIT;
            end
            ST_K1_WAIT:
            begin
                cmd.op = kaf_pkg::OP_DIV_K1;
                if (!status.div_busy) state_next = ST_Y;
            end
            ST_Y:       begin cmd.op = kaf_pkg::OP_Y;        state_next = ST_ACOR;  end
            ST_ACOR:    begin cmd.op = kaf_pkg::OP_ANG_COR;  state_next = ST_BCOR;  end
            ST_BCOR:    begin cmd.op = kaf_pkg::OP_BIAS_COR; state_next = ST_N00;   end
            ST_N00:     begin cmd.op = kaf_pkg::OP_NP00;     state_next = ST_N01;   end
            ST_N01:     begin cmd.op = kaf_pkg::OP_NP01;     state_next = ST_N10;   end
            ST_N10:     begin cmd.op = kaf_pkg::OP_NP10;     state_next = ST_N11;   end
            ST_N11:     begin cmd.op = kaf_pkg::OP_NP11;     state_next = ST_STORE; end
            ST_STORE:
            begin
                cmd.op         = kaf_pkg::OP_STORE;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_take_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == ST_LOAD))
        else $error("accepted item did not start processing");
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled result dropped");
    a_store_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STORE) |-> !(out_valid_reg && out_stall))
        else $error("result overwritten while waiting");
`endif

endmodule

>>> rtl/core/kalman_angle_filter_top.sv
// update: the gain divisions are skipped when S is not positive; otherwise each
//   division starts the serial divider, which works through all 60 dividend bits,
//   and then waits until the divider is done to pick up the quotient
// a new item is accepted only in the idle state, once the previous update has finished;
//   the result register frees the next accept as soon as it is taken
// reset: rst_n clears estimates and covariance of every axis to zero and loads
//   the noise registers with their defaults
module kalman_angle_filter_top #(
    parameter int unsigned NUM_AXES = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    // input item channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               axis,
    input  logic signed [31:0] measured_angle,
    input  logic signed [25:0] gyro_rate,
    input  logic [15:0]        time_step,
    // result item channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] filtered_angle,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data
);

    kaf_pkg::cmd_t    cmd;
    kaf_pkg::status_t status;
    logic             in_take;

    // registers are always writable
    assign cfg_ready = 1'b1;

    kaf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_take   (in_take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    kaf_datapath #(
        .NUM_AXES (NUM_AXES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_take        (in_take),
        .axis           (axis),
        .measured_angle (measured_angle),
        .gyro_rate      (gyro_rate),
        .time_step      (time_step),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result         (filtered_angle)
    );

endmodule
